@@ design/dfm_pkg.sv @@
// Package for the DFA state minimizer: sizes, item kinds, sequencer states
// and the run command struct. No dependencies.
package dfm_pkg;

  localparam int MAX_STATES = 64;
  localparam int ALPHABET   = 256;
  localparam int STATE_W    = 6;
  localparam int SYM_W      = 8;
  localparam int CNT_W      = 7;
  localparam int ENTRY_W    = 7;
  localparam int TADDR_W    = STATE_W + SYM_W;
  localparam int TDEPTH     = MAX_STATES * ALPHABET;
  localparam int KEY_SPAN   = MAX_STATES + 1;
  localparam int NONE_KEY   = MAX_STATES;
  localparam int PM_DEPTH   = MAX_STATES * KEY_SPAN;
  localparam int KEY_W      = 13;

  typedef enum logic [1:0] {
    KIND_LOAD = 2'd0,
    KIND_MARK = 2'd1,
    KIND_RUN  = 2'd2
  } kind_t;

  typedef enum logic [3:0] {
    R_CLR,
    R_IDLE,
    R_INIT,
    R_T,
    R_C,
    R_P,
    R_W,
    R_CP_R,
    R_CP_W,
    R_OUT_R,
    R_OUT_V
  } rstate_t;

  typedef struct packed {
    logic             start;
    logic [CNT_W-1:0] n;
  } run_cmd_t;

endpackage

@@ design/dfm_if.sv @@
// Valid/ready channel interfaces for input and result items.
// Depends on dfm_pkg.
interface dfm_req_if;
  import dfm_pkg::*;
  logic               valid;
  logic               ready;
  logic [1:0]         kind;
  logic [STATE_W-1:0] state_index;
  logic [SYM_W-1:0]   symbol;
  logic               has_next;
  logic [STATE_W-1:0] next_state;
  logic               accepting;
  logic [CNT_W-1:0]   state_count;
  modport source(output valid, kind, state_index, symbol, has_next, next_state,
                 accepting, state_count, input ready);
  modport sink(input valid, kind, state_index, symbol, has_next, next_state,
               accepting, state_count, output ready);
endinterface

interface dfm_rsp_if;
  import dfm_pkg::*;
  logic               valid;
  logic               ready;
  logic [STATE_W-1:0] orig_state;
  logic [STATE_W-1:0] class_index;
  logic [CNT_W-1:0]   class_count;
  logic               last;
  modport source(output valid, orig_state, class_index, class_count, last,
                 input ready);
  modport sink(input valid, orig_state, class_index, class_count, last,
               output ready);
endinterface

@@ design/dfm_trans_store.sv @@
// Transition store: one entry per (state, symbol), one write port and one
// registered read port. Depends on dfm_pkg.
module dfm_trans_store
  import dfm_pkg::*;
(
  input  logic               clk,
  input  logic               we,
  input  logic [TADDR_W-1:0] waddr,
  input  logic [ENTRY_W-1:0] wdata,
  input  logic [TADDR_W-1:0] raddr,
  output logic [ENTRY_W-1:0] rdata
);

  logic [ENTRY_W-1:0] mem [TDEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ design/dfm_refine.sv @@
// Partition refinement sequencer with class label, next label and pair map
// memories; emits result items. Depends on dfm_pkg and dfm_if.
module dfm_refine
  import dfm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  run_cmd_t              cmd,
  input  logic [MAX_STATES-1:0] acc,
  output logic                  idle,
  output logic [TADDR_W-1:0]    t_raddr,
  input  logic [ENTRY_W-1:0]    t_rdata,
  dfm_rsp_if.source             rsp
);

  rstate_t st, st_next;
  logic [STATE_W-1:0] idx, idx_next;
  logic [SYM_W-1:0]   sym, sym_next;
  logic               pass, pass_next;
  logic [CNT_W-1:0]   n, n_next;
  logic [CNT_W-1:0]   cnt, cnt_next;
  logic [CNT_W-1:0]   newcnt, newcnt_next;
  logic [CNT_W-1:0]   prior_cnt, prior_cnt_next;
  logic [KEY_W-1:0]   pclr, pclr_next;
  logic               have, have_next;
  logic [KEY_W-1:0]   key, key_next;

  // Memories and their registered read data
  logic [STATE_W-1:0] cl_mem [MAX_STATES];
  logic [STATE_W-1:0] nl_mem [MAX_STATES];
  logic [ENTRY_W-1:0] pm_mem [PM_DEPTH];
  logic [STATE_W-1:0] rd_a, rd_b, rd_nl;
  logic [ENTRY_W-1:0] rd_pm;

  logic               cl_we, nl_we, pm_we;
  logic [STATE_W-1:0] cl_waddr, cl_wdata, cl_raddr_b, nl_wdata;
  logic [KEY_W-1:0]   pm_addr;
  logic [ENTRY_W-1:0] pm_wdata;

  logic               is_last;
  logic [STATE_W-1:0] tgt;
  logic [CNT_W-1:0]   side;
  logic [KEY_W-1:0]   key_calc;

  assign is_last  = ({1'b0, idx} == n - CNT_W'(1));
  assign tgt      = t_rdata[STATE_W-1:0];
  assign side     = have ? {1'b0, rd_b} : CNT_W'(NONE_KEY);
  assign key_calc = KEY_W'(rd_a) * KEY_W'(KEY_SPAN) + KEY_W'(side);
  assign t_raddr  = {idx, sym};
  assign idle     = (st == R_IDLE);

  assign rsp.valid       = (st == R_OUT_V);
  assign rsp.orig_state  = idx;
  assign rsp.class_index = rd_a;
  assign rsp.class_count = cnt;
  assign rsp.last        = is_last;

  // Memory ports
  always_ff @(posedge clk) begin
    if (cl_we) begin
      cl_mem[cl_waddr] <= cl_wdata;
    end
    if (nl_we) begin
      nl_mem[idx] <= nl_wdata;
    end
    if (pm_we) begin
      pm_mem[pm_addr] <= pm_wdata;
    end
    rd_a  <= cl_mem[idx];
    rd_b  <= cl_mem[cl_raddr_b];
    rd_nl <= nl_mem[idx];
    rd_pm <= pm_mem[pm_addr];
  end

  // Sequencer registers
  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= R_CLR;
      pclr      <= '0;
      idx       <= '0;
      sym       <= '0;
      pass      <= 1'b0;
      n         <= '0;
      cnt       <= '0;
      newcnt    <= '0;
      prior_cnt <= '0;
      have      <= 1'b0;
      key       <= '0;
    end else begin
      st        <= st_next;
      pclr      <= pclr_next;
      idx       <= idx_next;
      sym       <= sym_next;
      pass      <= pass_next;
      n         <= n_next;
      cnt       <= cnt_next;
      newcnt    <= newcnt_next;
      prior_cnt <= prior_cnt_next;
      have      <= have_next;
      key       <= key_next;
    end
  end

  // Next state and memory controls
  always_comb begin
    st_next        = st;
    pclr_next      = pclr;
    idx_next       = idx;
    sym_next       = sym;
    pass_next      = pass;
    n_next         = n;
    cnt_next       = cnt;
    newcnt_next    = newcnt;
    prior_cnt_next = prior_cnt;
    have_next      = have;
    key_next       = key;
    cl_we          = 1'b0;
    cl_waddr       = idx;
    cl_wdata       = rd_nl;
    cl_raddr_b     = tgt;
    nl_we          = 1'b0;
    nl_wdata       = rd_pm[STATE_W-1:0] - STATE_W'(1);
    pm_we          = 1'b0;
    pm_addr        = key;
    pm_wdata       = '0;
    case (st)
      R_CLR: begin
        // Clear the pair map once after reset
        pm_we     = 1'b1;
        pm_addr   = pclr;
        pclr_next = pclr + KEY_W'(1);
        if (pclr == KEY_W'(PM_DEPTH - 1)) begin
          st_next = R_IDLE;
        end
      end
      R_IDLE: begin
        if (cmd.start) begin
          n_next   = cmd.n;
          idx_next = '0;
          cnt_next = CNT_W'(1);
          st_next  = R_INIT;
        end
      end
      R_INIT: begin
        // First partition: same mark as state 0 or not
        cl_we    = 1'b1;
        cl_wdata = {{(STATE_W-1){1'b0}}, acc[idx] != acc[0]};
        if (acc[idx] != acc[0]) begin
          cnt_next = CNT_W'(2);
        end
        if (is_last) begin
          idx_next       = '0;
          sym_next       = '0;
          pass_next      = 1'b0;
          newcnt_next    = '0;
          prior_cnt_next = (acc[idx] != acc[0]) ? CNT_W'(2) : cnt;
          st_next        = R_T;
        end else begin
          idx_next = idx + STATE_W'(1);
        end
      end
      R_T: begin
        st_next = R_C;
      end
      R_C: begin
        have_next = t_rdata[ENTRY_W-1] && ({1'b0, tgt} < n);
        st_next   = R_P;
      end
      R_P: begin
        key_next = key_calc;
        pm_addr  = key_calc;
        st_next  = R_W;
      end
      R_W: begin
        if (!pass) begin
          nl_we = 1'b1;
          if (rd_pm == '0) begin
            pm_we       = 1'b1;
            pm_wdata    = newcnt + CNT_W'(1);
            nl_wdata    = newcnt[STATE_W-1:0];
            newcnt_next = newcnt + CNT_W'(1);
          end
        end else begin
          pm_we = 1'b1;
        end
        if (is_last) begin
          idx_next = '0;
          if (!pass) begin
            pass_next = 1'b1;
            st_next   = R_T;
          end else begin
            st_next = R_CP_R;
          end
        end else begin
          idx_next = idx + STATE_W'(1);
          st_next  = R_T;
        end
      end
      R_CP_R: begin
        st_next = R_CP_W;
      end
      R_CP_W: begin
        cl_we = 1'b1;
        if (is_last) begin
          idx_next    = '0;
          cnt_next    = newcnt;
          newcnt_next = '0;
          pass_next   = 1'b0;
          st_next     = R_T;
          if (sym == SYM_W'(ALPHABET - 1)) begin
            sym_next = '0;
            if (newcnt == prior_cnt) begin
              st_next = R_OUT_R;
            end else begin
              prior_cnt_next = newcnt;
            end
          end else begin
            sym_next = sym + SYM_W'(1);
          end
        end else begin
          idx_next = idx + STATE_W'(1);
          st_next  = R_CP_R;
        end
      end
      R_OUT_R: begin
        st_next = R_OUT_V;
      end
      R_OUT_V: begin
        if (rsp.ready) begin
          if (is_last) begin
            st_next = R_IDLE;
          end else begin
            idx_next = idx + STATE_W'(1);
            st_next  = R_OUT_R;
          end
        end
      end
      default: begin
        st_next = R_IDLE;
      end
    endcase
  end

  // Class count stays within the states in use
  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> (cnt != '0) && (cnt <= n))
    else $error("class count out of range");

  // Emitted class lies below the class count
  a_class_lt: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> ({1'b0, rsp.class_index} < cnt))
    else $error("class index not below class count");

  // State 0 always opens class 0
  a_first_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && idx == '0) |-> (rsp.class_index == '0))
    else $error("state 0 not in class 0");

  // New classes never outnumber states
  a_newcnt: assert property (@(posedge clk) disable iff (rst)
    (st == R_W) |-> (newcnt <= n))
    else $error("split produced too many classes");

endmodule

@@ design/dfa_state_minimizer.sv @@
// DFA state minimizer. Load and mark items are taken whenever the block is
// ready. A run item refines the first n states in rounds over all 256 symbols
// until the class count no longer changes (at least one round): for each
// symbol the shared key/lookup sequencer assigns new labels, clears the pair
// map and copies labels, state by state. Then results leave one at a time,
// each after its own read, and are held while the receiver stalls. After reset
// a clearing pass runs over all 16384 entries of the transition store, during
// which no item is accepted; the 4160-entry pair map is cleared in the same window.
module dfa_state_minimizer
  import dfm_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  dfm_req_if.sink   req,
  dfm_rsp_if.source rsp
);

  logic [TADDR_W:0]       clr;
  logic                   clearing;
  logic [MAX_STATES-1:0]  acc;
  logic                   ref_idle;
  logic                   take;
  logic                   t_we;
  logic [TADDR_W-1:0]     t_waddr, t_raddr;
  logic [ENTRY_W-1:0]     t_wdata, t_rdata;
  logic [CNT_W-1:0]       n_eff;
  run_cmd_t               cmd;

  assign clearing  = !clr[TADDR_W];
  assign req.ready = !clearing && ref_idle;
  assign take      = req.valid && req.ready;
  assign n_eff     = (req.state_count > CNT_W'(MAX_STATES)) ?
                     CNT_W'(MAX_STATES) : req.state_count;

  // Start a run on a run item with at least one state
  always_comb begin
    cmd.start = take && (req.kind == KIND_RUN) && (n_eff != '0);
    cmd.n     = n_eff;
  end

  // Transition store write: clearing sweep or load item
  always_comb begin
    t_we    = clearing || (take && (req.kind == KIND_LOAD));
    t_waddr = clearing ? clr[TADDR_W-1:0] : {req.state_index, req.symbol};
    t_wdata = (clearing || !req.has_next) ? '0 : {1'b1, req.next_state};
  end

  // Advance the clearing sweep; hold accepting marks
  always_ff @(posedge clk) begin
    if (rst) begin
      clr <= '0;
      acc <= '0;
    end else begin
      if (clearing) begin
        clr <= clr + (TADDR_W+1)'(1);
      end
      if (take && (req.kind == KIND_MARK)) begin
        acc[req.state_index] <= req.accepting;
      end
    end
  end

  dfm_trans_store u_store (
    .clk   (clk),
    .we    (t_we),
    .waddr (t_waddr),
    .wdata (t_wdata),
    .raddr (t_raddr),
    .rdata (t_rdata)
  );

  dfm_refine u_refine (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .acc     (acc),
    .idle    (ref_idle),
    .t_raddr (t_raddr),
    .t_rdata (t_rdata),
    .rsp     (rsp)
  );

endmodule

@@ test/dfa_state_minimizer_checker.sv @@
// Checker for the DFA state minimizer: watches the input and result channels,
// predicts the class of each state and compares. Depends on dfm_pkg, dfm_if.
module dfa_state_minimizer_checker
  import dfm_pkg::*;
(
  input  logic clk,
  input  logic rst,
  dfm_req_if   req,
  dfm_rsp_if   rsp,
  output int   failures,
  output int   pending
);

  typedef struct {
    logic [STATE_W-1:0] orig_state;
    logic [STATE_W-1:0] class_index;
    logic [CNT_W-1:0]   class_count;
    logic               last;
  } class_result_t;

  // Predictor state: transitions as {has, target}, accepting marks
  logic [ENTRY_W-1:0] trans_table [MAX_STATES][ALPHABET];
  logic               accept_set  [MAX_STATES];
  int                 class_total;
  class_result_t      class_queue [$];

  // Moore refinement over the first n states; queue one result per state
  function automatic void refine_partition(int unsigned n_raw);
    int n, cnt, prior, side, key, s, sym;
    int lbl [MAX_STATES];
    int nxt [MAX_STATES];
    int pmap [PM_DEPTH];
    class_result_t res;
    n = (n_raw > MAX_STATES) ? MAX_STATES : int'(n_raw);
    if (n == 0) begin
      class_total = 0;
      return;
    end
    foreach (pmap[j]) pmap[j] = -1;
    cnt = 1;
    for (s = 0; s < n; s++) begin
      if (accept_set[s] == accept_set[0]) begin
        lbl[s] = 0;
      end else begin
        lbl[s] = 1;
        cnt = 2;
      end
    end
    do begin
      prior = cnt;
      for (sym = 0; sym < ALPHABET; sym++) begin
        cnt = 0;
        for (s = 0; s < n; s++) begin
          side = NONE_KEY;
          if (trans_table[s][sym][6] && trans_table[s][sym][5:0] < n)
            side = lbl[trans_table[s][sym][5:0]];
          key = lbl[s] * KEY_SPAN + side;
          if (pmap[key] < 0) begin
            pmap[key] = cnt;
            cnt++;
          end
          nxt[s] = pmap[key];
        end
        // drop the keys of this symbol before the next one
        for (s = 0; s < n; s++) begin
          side = NONE_KEY;
          if (trans_table[s][sym][6] && trans_table[s][sym][5:0] < n)
            side = lbl[trans_table[s][sym][5:0]];
          pmap[lbl[s] * KEY_SPAN + side] = -1;
        end
        for (s = 0; s < n; s++) lbl[s] = nxt[s];
      end
    end while (cnt != prior);
    class_total = cnt;
    for (s = 0; s < n; s++) begin
      res.orig_state  = STATE_W'(s);
      res.class_index = STATE_W'(lbl[s]);
      res.class_count = CNT_W'(cnt);
      res.last        = (s == n - 1);
      class_queue.push_back(res);
    end
  endfunction

  // Compare results first, then take in the accepted item
  always @(posedge clk) begin
    class_result_t exp_res;
    if (rst) begin
      foreach (trans_table[a, b]) trans_table[a][b] = '0;
      foreach (accept_set[a]) accept_set[a] = 1'b0;
      class_total = 0;
      class_queue.delete();
      failures <= 0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        if (class_queue.size() == 0) begin
          failures <= failures + 1;
          if (failures < 10)
            $display("unexpected result: state %0d class %0d count %0d last %0b",
                     rsp.orig_state, rsp.class_index, rsp.class_count, rsp.last);
        end else begin
          exp_res = class_queue.pop_front();
          if (rsp.orig_state !== exp_res.orig_state ||
              rsp.class_index !== exp_res.class_index ||
              rsp.class_count !== exp_res.class_count ||
              rsp.last !== exp_res.last) begin
            failures <= failures + 1;
            if (failures < 10)
              $display("mismatch: exp state %0d class %0d count %0d last %0b, got %0d %0d %0d %0b",
                       exp_res.orig_state, exp_res.class_index, exp_res.class_count,
                       exp_res.last, rsp.orig_state, rsp.class_index,
                       rsp.class_count, rsp.last);
          end
        end
      end
      if (req.valid && req.ready) begin
        case (req.kind)
          KIND_LOAD: trans_table[req.state_index][req.symbol] =
                       req.has_next ? {1'b1, req.next_state} : '0;
          KIND_MARK: accept_set[req.state_index] = req.accepting;
          KIND_RUN:  refine_partition(req.state_count);
          default: ;
        endcase
      end
    end
    pending <= class_queue.size();
  end

  // Flag results left over is handled by the top through pending
endmodule

@@ test/dfa_state_minimizer_test.sv @@
// Testbench top for the DFA state minimizer: clock, reset, stimulus and the
// verdict. Depends on dfm_pkg, dfm_if, the block and its checker.
module dfa_state_minimizer_test;
  import dfm_pkg::*;

  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 20000000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   failures, pending;
  int   cycles = 0;
  int   send_idle = 30;
  int   recv_idle = 70;

  dfm_req_if req ();
  dfm_rsp_if rsp ();

  dfa_state_minimizer i_dut (.clk(clk), .rst(rst), .req(req), .rsp(rsp));

  dfa_state_minimizer_checker i_checker (
    .clk(clk), .rst(rst), .req(req), .rsp(rsp),
    .failures(failures), .pending(pending)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Bound the run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Stall the result side
  always @(negedge clk) begin
    rsp.ready <= ($urandom_range(0, 99) >= recv_idle);
  end

  // Hand one item over; wait for acceptance, then return at a falling edge
  task automatic send_item(logic [1:0] kind, int si, int sym, bit has, int nx,
                           bit acc, int n);
    while ($urandom_range(0, 99) < send_idle) begin
      req.valid <= 1'b0;
      @(negedge clk);
    end
    req.valid       <= 1'b1;
    req.kind        <= kind;
    req.state_index <= STATE_W'(si);
    req.symbol      <= SYM_W'(sym);
    req.has_next    <= has;
    req.next_state  <= STATE_W'(nx);
    req.accepting   <= acc;
    req.state_count <= CNT_W'(n);
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic int pick_state();
    return ($urandom_range(0, 7) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 5);
  endfunction

  initial begin
    int r, n;
    req.valid = 1'b0;
    req.kind = KIND_LOAD;
    req.state_index = '0;
    req.symbol = '0;
    req.has_next = 1'b0;
    req.next_state = '0;
    req.accepting = 1'b0;
    req.state_count = '0;
    rsp.ready = 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: empty run, saturated count on an empty store, unknown kind
    send_item(KIND_RUN, 0, 0, 0, 0, 0, 0);
    send_item(KIND_MARK, 5, 0, 0, 0, 1, 0);
    send_item(KIND_MARK, 63, 0, 0, 0, 1, 0);
    send_item(KIND_RUN, 0, 0, 0, 0, 0, 127);
    send_item(KIND_UNUSED, 63, 255, 1, 63, 1, 127);
    send_item(KIND_LOAD, 63, 255, 1, 63, 0, 0);
    send_item(KIND_MARK, 63, 0, 0, 0, 0, 0);
    send_item(KIND_MARK, 5, 0, 0, 0, 0, 0);
    // chain 0 -> 1 -> 2 -> 3 on symbol 0, state 3 accepting
    send_item(KIND_LOAD, 0, 0, 1, 1, 0, 0);
    send_item(KIND_LOAD, 1, 0, 1, 2, 0, 0);
    send_item(KIND_LOAD, 2, 0, 1, 3, 0, 0);
    send_item(KIND_MARK, 3, 0, 0, 0, 1, 0);
    send_item(KIND_RUN, 0, 0, 0, 0, 0, 4);
    // all accepting; then target outside the used states
    send_item(KIND_MARK, 0, 0, 0, 0, 1, 0);
    send_item(KIND_MARK, 1, 0, 0, 0, 1, 0);
    send_item(KIND_MARK, 2, 0, 0, 0, 1, 0);
    send_item(KIND_RUN, 0, 0, 0, 0, 0, 3);
    send_item(KIND_LOAD, 0, 7, 1, 60, 0, 0);
    send_item(KIND_LOAD, 1, 0, 0, 0, 0, 0);
    send_item(KIND_RUN, 0, 0, 0, 0, 0, 2);
    send_item(KIND_RUN, 0, 0, 0, 0, 0, 1);

    // Random: small machines, occasional noise
    for (int i = 0; i < 310; i++) begin
      if (i == 100) begin
        send_idle = 70;
        recv_idle = 30;
      end else if (i == 200) begin
        send_idle = 0;
        recv_idle = 0;
      end
      r = $urandom_range(0, 99);
      if (r < 3) begin
        send_item(KIND_UNUSED, $urandom_range(0, 63), $urandom_range(0, 255),
                  $urandom_range(0, 1), $urandom_range(0, 63), $urandom_range(0, 1),
                  $urandom_range(0, 127));
      end else if (r < 9) begin
        n = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 6) : $urandom_range(1, 4);
        send_item(KIND_RUN, $urandom_range(0, 63), $urandom_range(0, 255), 0, 0, 0, n);
      end else if (r < 25) begin
        send_item(KIND_MARK, pick_state(), 0, 0, 0, $urandom_range(0, 1), 0);
      end else begin
        send_item(KIND_LOAD, pick_state(),
                  ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 2),
                  ($urandom_range(0, 4) != 0), pick_state(), 0, 0);
      end
    end
    req.valid <= 1'b0;

    // Drain, then allow the trailing latency
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (64) @(posedge clk);
    if (failures == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
